>>> rtl/i2r_pkg.sv
// shared types, constants and numeral tables for the roman numeral encoder
package i2r_pkg;

    localparam int VALUE_W  = 12;
    localparam int LETTER_W = 7;
    localparam int POS_W    = 4;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

    // ascii codes of the numeral letters
    localparam logic [LETTER_W-1:0] LETTER_NONE = 7'h00;
    localparam logic [LETTER_W-1:0] LETTER_I    = 7'h49;
    localparam logic [LETTER_W-1:0] LETTER_V    = 7'h56;
    localparam logic [LETTER_W-1:0] LETTER_X    = 7'h58;
    localparam logic [LETTER_W-1:0] LETTER_L    = 7'h4C;
    localparam logic [LETTER_W-1:0] LETTER_C    = 7'h43;
    localparam logic [LETTER_W-1:0] LETTER_D    = 7'h44;
    localparam logic [LETTER_W-1:0] LETTER_M    = 7'h4D;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } i2r_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic hold;
        logic step_last;
    } i2r_status_t;

    // weight of each table entry
    function automatic logic [VALUE_W-1:0] roman_weight(input logic [POS_W-1:0] pos);
        logic [VALUE_W-1:0] w;
        case (pos)
            4'd0:    w = 12'd1000;
            4'd1:    w = 12'd900;
            4'd2:    w = 12'd500;
            4'd3:    w = 12'd400;
            4'd4:    w = 12'd100;
            4'd5:    w = 12'd90;
            4'd6:    w = 12'd50;
            4'd7:    w = 12'd40;
            4'd8:    w = 12'd10;
            4'd9:    w = 12'd9;
            4'd10:   w = 12'd5;
            4'd11:   w = 12'd4;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    // first letter of each table entry
    function automatic logic [LETTER_W-1:0] roman_first(input logic [POS_W-1:0] pos);
        logic [LETTER_W-1:0] ch;
        case (pos)
            4'd0:    ch = LETTER_M;
            4'd1:    ch = LETTER_C;
            4'd2:    ch = LETTER_D;
            4'd3:    ch = LETTER_C;
            4'd4:    ch = LETTER_C;
            4'd5:    ch = LETTER_X;
            4'd6:    ch = LETTER_L;
            4'd7:    ch = LETTER_X;
            4'd8:    ch = LETTER_X;
            4'd9:    ch = LETTER_I;
            4'd10:   ch = LETTER_V;
            default: ch = LETTER_I;
        endcase
        return ch;
    endfunction

    // second letter of a pair entry, none for single letters
    function automatic logic [LETTER_W-1:0] roman_second(input logic [POS_W-1:0] pos);
        logic [LETTER_W-1:0] ch;
        case (pos)
            4'd1:    ch = LETTER_M;
            4'd3:    ch = LETTER_D;
            4'd5:    ch = LETTER_C;
            4'd7:    ch = LETTER_L;
            4'd9:    ch = LETTER_X;
            4'd11:   ch = LETTER_V;
            default: ch = LETTER_NONE;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/i2r_datapath.sv
// remainder, table position and output register of the roman numeral encoder
module i2r_datapath
    import i2r_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  i2r_cmd_t            cmd,
    output i2r_status_t         status,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LETTER_W-1:0] letter,
    output logic                last
);

    logic [VALUE_W-1:0]  remainder_reg, remainder_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                pending_reg, pending_next;
    logic                out_valid_reg, out_valid_next;
    logic [LETTER_W-1:0] letter_reg, letter_next;
    logic                last_reg, last_next;

    logic [VALUE_W-1:0]  weight;
    logic [LETTER_W-1:0] second_ch;
    logic                emit;
    logic [LETTER_W-1:0] emit_ch;
    logic                hold;

    assign weight    = roman_weight(pos_reg);
    assign second_ch = roman_second(pos_reg);
    assign hold      = out_valid_reg && out_stall;

    // one greedy step: second letter, first letter, or advance the table
    always_comb
    begin
        remainder_next = remainder_reg;
        pos_next       = pos_reg;
        pending_next   = pending_reg;
        emit           = 1'b0;
        emit_ch        = roman_first(pos_reg);
        if (pending_reg)
        begin
            emit         = 1'b1;
            emit_ch      = second_ch;
            pending_next = 1'b0;
        end
        else if (remainder_reg >= weight)
        begin
            emit           = 1'b1;
            remainder_next = remainder_reg - weight;
            pending_next   = (second_ch != LETTER_NONE);
        end
        else
        begin
            pos_next = pos_reg + 4'd1;
        end
    end

    assign status.hold      = hold;
    assign status.step_last = emit && (remainder_next == '0) && !pending_next;

    // output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg;
        letter_next    = letter_reg;
        last_next      = last_reg;
        if (!hold)
        begin
            out_valid_next = cmd.step && emit;
            if (cmd.step && emit)
            begin
                letter_next = emit_ch;
                last_next   = status.step_last;
            end
        end
    end

    // conversion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remainder_reg <= '0;
            pos_reg       <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                remainder_reg <= (value > VALUE_MAX) ? VALUE_MAX : value;
                pos_reg       <= '0;
                pending_reg   <= 1'b0;
            end
            else if (cmd.step)
            begin
                remainder_reg <= remainder_next;
                pos_reg       <= pos_next;
                pending_reg   <= pending_next;
            end
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign letter    = letter_reg;
    assign last      = last_reg;

endmodule

>>> rtl/i2r_controller.sv
// sequencing state machine of the roman numeral encoder
module i2r_controller
    import i2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        value_zero,
    output i2r_cmd_t    cmd,
    input  i2r_status_t status
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;
    logic accept;

    assign in_stall = (state_reg == ST_RUN);
    assign accept   = in_valid && !in_stall;

    // a zero value is taken but starts no conversion
    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !value_zero)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = !status.hold;
                if (!status.hold && status.step_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/integer_to_roman_encoder.sv
// top level of the roman numeral encoder: controller plus datapath
//
//   channel   signals                         direction  payload
//   input     in_valid, in_stall, value       in         12-bit number, 1..3999
//   output    out_valid, out_stall, letter    out        7-bit ascii letter, last flag
//
// one number at a time: after a transfer in, each cycle of the greedy loop
// either emits one letter or moves one table entry on, so a number needs
// its letter count plus up to 12 table steps (3888: fifteen letters and
// twelve table steps). a value of zero is taken and gives no letters.
// output stall freezes the loop; a new number is taken once the last
// letter sits in the output register. reset clears all control state.
module integer_to_roman_encoder
    import i2r_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LETTER_W-1:0] letter,
    output logic                last
);

    i2r_cmd_t    cmd;
    i2r_status_t status;

    i2r_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_zero (value == '0),
        .cmd        (cmd),
        .status     (status)
    );

    i2r_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .letter    (letter),
        .last      (last)
    );

endmodule

>>> rtl/i2r_checker.sv
// port-level checks of the roman numeral encoder, bound to the top level
module i2r_checker
    import i2r_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [VALUE_W-1:0]  value,
    input logic                out_valid,
    input logic                out_stall,
    input logic [LETTER_W-1:0] letter,
    input logic                last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(letter) && $stable(last))
    else $error("stalled result changed");

    // a nonzero number starts a conversion
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && value != '0 |=> in_stall)
    else $error("nonzero transfer did not start conversion");

    // zero gives no conversion
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && value == '0 |=> !in_stall)
    else $error("zero transfer started conversion");

    // only numeral letters leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> letter == LETTER_I || letter == LETTER_V || letter == LETTER_X
            || letter == LETTER_L || letter == LETTER_C || letter == LETTER_D
            || letter == LETTER_M)
    else $error("letter is not a numeral");

endmodule

bind integer_to_roman_encoder i2r_checker u_i2r_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .letter    (letter),
    .last      (last)
);

>>> tb/roman_numeral_checker.sv
// checker for the roman numeral encoder: watches both channels, predicts and compares letters
module roman_numeral_checker
    import i2r_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [VALUE_W-1:0]  value,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [LETTER_W-1:0] letter,
    input  logic                last,
    output int                  mismatches,
    output int                  letters_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [LETTER_W-1:0] code;
        logic                final_letter;
    } roman_letter_t;

    roman_letter_t expected_letters[$];
    int            mismatch_count = 0;

    // print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [LETTER_W-1:0] want,
                                   input logic [LETTER_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
    endtask

    function automatic void push_letter(input logic [LETTER_W-1:0] code);
        roman_letter_t entry;
        entry.code         = code;
        entry.final_letter = 1'b0;
        expected_letters.push_back(entry);
    endfunction

    // one decimal digit written with its unit, half and next-unit letters
    function automatic void push_digit(input int digit, input logic [LETTER_W-1:0] one,
                                       input logic [LETTER_W-1:0] five,
                                       input logic [LETTER_W-1:0] ten);
        if (digit == 9)
        begin
            push_letter(one);
            push_letter(ten);
        end
        else if (digit == 4)
        begin
            push_letter(one);
            push_letter(five);
        end
        else
        begin
            if (digit >= 5)
                push_letter(five);
            for (int n = digit % 5; n > 0; n--)
                push_letter(one);
        end
    endfunction

    // letters of one accepted number; above the range it saturates, zero gives none
    function automatic void predict_numeral(input logic [VALUE_W-1:0] number);
        int            amount;
        int            earlier_count;
        roman_letter_t tail;
        amount        = (number > VALUE_MAX) ? int'(VALUE_MAX) : int'(number);
        earlier_count = expected_letters.size();
        push_digit(amount / 1000, LETTER_M, LETTER_NONE, LETTER_NONE);
        push_digit((amount / 100) % 10, LETTER_C, LETTER_D, LETTER_M);
        push_digit((amount / 10) % 10, LETTER_X, LETTER_L, LETTER_C);
        push_digit(amount % 10, LETTER_I, LETTER_V, LETTER_X);
        // flag the closing letter of this numeral
        if (expected_letters.size() > earlier_count)
        begin
            tail              = expected_letters.pop_back();
            tail.final_letter = 1'b1;
            expected_letters.push_back(tail);
        end
    endfunction

    // letter transfer is checked first: it always belongs to an earlier number
    always @(posedge clk)
    begin
        roman_letter_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_letters.size() == 0)
                    report_mismatch("unexpected letter", LETTER_NONE, letter);
                else
                begin
                    want = expected_letters.pop_front();
                    if (letter !== want.code)
                        report_mismatch("letter", want.code, letter);
                    if (last !== want.final_letter)
                        report_mismatch("last flag", LETTER_W'(want.final_letter),
                                        LETTER_W'(last));
                end
            end
            if (in_valid && !in_stall)
                predict_numeral(value);
        end
        mismatches      <= mismatch_count;
        letters_pending <= expected_letters.size();
    end

endmodule

>>> tb/integer_to_roman_encoder_test.sv
// test top for the roman numeral encoder: clock, reset, number stimulus and verdict
module integer_to_roman_encoder_test
    import i2r_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_NUMBERS = 52;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [VALUE_W-1:0]  value;
    logic                out_valid;
    logic                out_stall;
    logic [LETTER_W-1:0] letter;
    logic                last;
    int                  mismatches;
    int                  letters_pending;
    int                  send_gap_pct;
    int                  stall_pct;
    logic                hold_request;

    integer_to_roman_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .letter    (letter),
        .last      (last)
    );

    roman_numeral_checker numeral_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .value           (value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .letter          (letter),
        .last            (last),
        .mismatches      (mismatches),
        .letters_pending (letters_pending)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // offer one number, with a random gap first, and hold it until the transfer
    task automatic send_number(input logic [VALUE_W-1:0] number);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= number;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // mostly in-range numbers, some built digit by digit, some zero or above the range
    task automatic send_random(input int count);
        logic [VALUE_W-1:0] number;
        int                 pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                number = VALUE_W'($urandom_range(3999, 1));
            else if (pick < 85)
                number = VALUE_W'(1000 * $urandom_range(3) + 100 * $urandom_range(9)
                                  + 10 * $urandom_range(9) + $urandom_range(9));
            else if (pick < 95)
                number = VALUE_W'($urandom_range(4095, 4000));
            else
                number = '0;
            send_number(number);
        end
    endtask

    // receiver: random stalls, and one long hold-off once it is asked for
    initial
    begin
        int held_cycles;
        held_cycles = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && held_cycles < HOLD_CYCLES)
            begin
                out_stall <= 1'b1;
                held_cycles++;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("integer_to_roman_encoder_test NOT OK");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        logic [VALUE_W-1:0] corner_numbers[$];
        corner_numbers = {12'd1, 12'd3999, 12'd3888, 12'd0, 12'd4000, 12'd4095,
                          12'd4, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900,
                          12'd5, 12'd50, 12'd500, 12'd1000, 12'd3, 12'd2,
                          12'd2048, 12'd1994, 12'd444, 12'd999, 12'd3000, 12'd2777};
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        value        <= '0;
        hold_request <= 1'b0;
        stall_pct    <= 85;
        send_gap_pct = 15;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // range ends, the table entries but 10 and 100, saturation, zero and the longest numeral
        foreach (corner_numbers[i])
            send_number(corner_numbers[i]);

        // sender rarely idle, receiver mostly stalled
        send_random(PHASE_NUMBERS);

        // sender mostly idle, receiver rarely stalled
        send_gap_pct = 85;
        stall_pct    <= 15;
        send_random(PHASE_NUMBERS);

        // no idling, opened by a long hold-off so the block backs up
        send_gap_pct = 0;
        stall_pct    <= 0;
        hold_request <= 1'b1;
        send_random(PHASE_NUMBERS);
        in_valid <= 1'b0;

        // drain the remaining letters, then watch for strays
        @(posedge clk);
        while (letters_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && letters_pending == 0)
            $display("integer_to_roman_encoder_test OK");
        else
            $display("integer_to_roman_encoder_test NOT OK");
        $finish;
    end

endmodule
